// ----- hdl/bale_pkg.sv -----
package bale_pkg;

    // default store depth and capacity after reset
    localparam int DEPTH_DEF = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_WRITE   = 3'd4;
    localparam logic [2:0] OP_LSEARCH = 3'd5;
    localparam logic [2:0] OP_BSEARCH = 3'd6;
    localparam logic [2:0] OP_SINSERT = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    // one request beat
    typedef struct packed {
        logic signed [31:0] search_key;
        logic signed [31:0] data_word;
        logic [4:0]         position;
        logic [2:0]         operation;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [4:0]         element_count;
        logic [3:0]         found_index;
        logic signed [31:0] read_word;
        logic [1:0]         status;
    } result_t;

endpackage

// ----- hdl/bale_core.sv -----
module bale_core #(
    parameter int DEPTH = bale_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bale_pkg::item_t   item,
    input  logic [4:0]        cap_limit,
    input  logic              take,
    output logic              idle,
    output logic              done,
    output bale_pkg::result_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_SHUP  = 4'd3;
    localparam logic [3:0] S_PUT   = 4'd4;
    localparam logic [3:0] S_DEL1  = 4'd5;
    localparam logic [3:0] S_SHDN  = 4'd6;
    localparam logic [3:0] S_LSCAN = 4'd7;
    localparam logic [3:0] S_SWAP  = 4'd8;
    localparam logic [3:0] S_BISS  = 4'd9;
    localparam logic [3:0] S_BCMP  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]         state_reg, state_next;
    bale_pkg::item_t    item_reg, item_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hip_reg, hip_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [CW-1:0]      found_reg, found_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] word_reg, word_next;
    logic signed [31:0] prev_reg, prev_next;

    // list storage, one write and one registered read per cycle
    logic signed [31:0] mem_array [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [AW-1:0]      rd_addr;

    // pointer neighbors and comparisons
    logic [CW-1:0] ptr_dec, ptr_dec2, ptr_inc, ptr_inc2, cnt_dec, pos_cw, mid_inc;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_calc;
    logic [LW-1:0] pos_ext, cnt_ext, cap_ext, depth_ext, lim_ext;
    logic          full, move, stop;

    always_comb
    begin
        ptr_dec   = ptr_reg - 1'b1;
        ptr_dec2  = ptr_reg - 2'd2;
        ptr_inc   = ptr_reg + 1'b1;
        ptr_inc2  = ptr_reg + 2'd2;
        cnt_dec   = count_reg - 1'b1;
        pos_cw    = CW'(item_reg.position);
        mid_inc   = mid_reg + 1'b1;
        mid_sum   = {1'b0, lo_reg} + {1'b0, hip_reg} - 1'b1;
        mid_calc  = mid_sum[CW:1];
        pos_ext   = LW'(item_reg.position);
        cnt_ext   = LW'(count_reg);
        cap_ext   = LW'(cap_limit);
        depth_ext = LW'(DEPTH);
        lim_ext   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
        full      = (cnt_ext >= lim_ext);
        move      = (item_reg.operation == bale_pkg::OP_INSERT) ||
                    (rd_data_reg > item_reg.data_word);
        stop      = (item_reg.operation == bale_pkg::OP_INSERT) ? (ptr_dec == pos_cw)
                                                                : (ptr_dec == '0);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        lo_next     = lo_reg;
        hip_next    = hip_reg;
        mid_next    = mid_reg;
        found_next  = found_reg;
        status_next = status_reg;
        word_next   = word_reg;
        prev_next   = prev_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_addr     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    status_next = bale_pkg::ST_OK;
                    word_next   = '0;
                    found_next  = '0;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                state_next = S_DONE;
                case (item_reg.operation)
                    bale_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = item_reg.data_word;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bale_pkg::OP_INSERT:
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            status_next = bale_pkg::ST_RANGE;
                        end
                        else if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else
                        begin
                            ptr_next   = count_reg;
                            rd_addr    = cnt_dec[AW-1:0];
                            state_next = (pos_cw == count_reg) ? S_PUT : S_SHUP;
                        end
                    end
                    bale_pkg::OP_DELETE, bale_pkg::OP_READ:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            status_next = bale_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = pos_cw;
                            rd_addr    = pos_cw[AW-1:0];
                            state_next = (item_reg.operation == bale_pkg::OP_READ) ? S_READ
                                                                                   : S_DEL1;
                        end
                    end
                    bale_pkg::OP_WRITE:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            status_next = bale_pkg::ST_RANGE;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pos_cw[AW-1:0];
                            wr_data = item_reg.data_word;
                        end
                    end
                    bale_pkg::OP_LSEARCH:
                    begin
                        status_next = bale_pkg::ST_MISS;
                        ptr_next    = '0;
                        rd_addr     = '0;
                        if (count_reg != '0)
                        begin
                            state_next = S_LSCAN;
                        end
                    end
                    bale_pkg::OP_BSEARCH:
                    begin
                        status_next = bale_pkg::ST_MISS;
                        lo_next     = '0;
                        hip_next    = count_reg;
                        state_next  = S_BISS;
                    end
                    default:
                    begin
                        if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else
                        begin
                            ptr_next   = count_reg;
                            rd_addr    = cnt_dec[AW-1:0];
                            state_next = (count_reg == '0) ? S_PUT : S_SHUP;
                        end
                    end
                endcase
            end
            S_SHUP:
            begin
                // move the entry below the pointer one place up
                if (move)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ptr_reg[AW-1:0];
                    wr_data    = rd_data_reg;
                    ptr_next   = ptr_dec;
                    rd_addr    = ptr_dec2[AW-1:0];
                    state_next = stop ? S_PUT : S_SHUP;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[AW-1:0];
                wr_data    = item_reg.data_word;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_READ:
            begin
                word_next  = rd_data_reg;
                state_next = S_DONE;
            end
            S_DEL1:
            begin
                word_next = rd_data_reg;
                rd_addr   = ptr_inc[AW-1:0];
                if (ptr_inc == count_reg)
                begin
                    count_next = cnt_dec;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHDN;
                end
            end
            S_SHDN:
            begin
                // move the entry above the pointer one place down
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                wr_data  = rd_data_reg;
                rd_addr  = ptr_inc2[AW-1:0];
                ptr_next = ptr_inc;
                if (ptr_inc2 == count_reg)
                begin
                    count_next = cnt_dec;
                    state_next = S_DONE;
                end
            end
            S_LSCAN:
            begin
                if (rd_data_reg == item_reg.search_key)
                begin
                    status_next = bale_pkg::ST_OK;
                    if (ptr_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ptr_reg[AW-1:0];
                        wr_data    = prev_reg;
                        found_next = ptr_dec;
                        state_next = S_SWAP;
                    end
                end
                else
                begin
                    prev_next = rd_data_reg;
                    ptr_next  = ptr_inc;
                    rd_addr   = ptr_inc[AW-1:0];
                    if (ptr_inc == count_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SWAP:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_dec[AW-1:0];
                wr_data    = item_reg.search_key;
                state_next = S_DONE;
            end
            S_BISS:
            begin
                if (lo_reg < hip_reg)
                begin
                    mid_next   = mid_calc;
                    rd_addr    = mid_calc[AW-1:0];
                    state_next = S_BCMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BCMP:
            begin
                if (item_reg.search_key == rd_data_reg)
                begin
                    status_next = bale_pkg::ST_OK;
                    found_next  = mid_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (item_reg.search_key < rd_data_reg)
                    begin
                        hip_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_inc;
                    end
                    state_next = S_BISS;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        ptr_reg    <= ptr_next;
        lo_reg     <= lo_next;
        hip_reg    <= hip_next;
        mid_reg    <= mid_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        word_reg   <= word_next;
        prev_reg   <= prev_next;
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    // result
    assign idle                 = (state_reg == S_IDLE);
    assign done                 = (state_reg == S_DONE);
    assign result.status        = status_reg;
    assign result.read_word     = word_reg;
    assign result.found_index   = 4'(found_reg);
    assign result.element_count = 5'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above store depth");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("store written outside an operation");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) ||
        (count_reg == $past(count_reg) - 1'b1))
        else $error("element count moved by more than one");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after result handoff");

endmodule

// ----- hdl/bounded_array_list_engine.sv -----
// Bounded array list: a list of up to DEPTH signed 32-bit words plus a length.
// Request channel s_*: one beat carries one operation (append, insert, delete,
// read, write, linear search with move toward front, binary search, sorted
// insert). Result channel m_*: exactly one beat per request with status,
// word read or deleted, index of a search hit and the new element count.
// cfg_wr_en / cfg_wr_data set the capacity limit; write it only while idle.
// Sequencer occupancy: append and write need no shifting; a shifting insert or
// delete and a linear search grow with the element count, and each binary
// search probe passes through an issue state and a compare state. The single
// memory port, one entry read and one written per cycle, moves or scans one
// entry per step. The result is registered when the sequencer hands it off.
// One request is worked at a time; s_tready is high whenever the sequencer is idle.
// If the receiver stalls, the result waits in the output register while the
// next request is taken; that request's result waits in the sequencer.
// Reset: list empty, capacity limit 16, no result pending.
module bounded_array_list_engine #(
    parameter int DEPTH = bale_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,     // operation, position, data_word, search_key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // status, read_word, found_index, element_count, pad
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data  // capacity_limit
);

    logic [4:0]        cap_reg;
    logic              m_valid_reg;
    logic [47:0]       m_data_reg;
    bale_pkg::item_t   item;
    bale_pkg::result_t result;
    logic              start, take, core_idle, core_done;

    // request beat unpack
    assign item.operation  = s_tdata[2:0];
    assign item.position   = s_tdata[7:3];
    assign item.data_word  = s_tdata[39:8];
    assign item.search_key = s_tdata[71:40];

    assign s_tready = core_idle;
    assign start    = s_tvalid && core_idle;
    assign take     = core_done && (!m_valid_reg || m_tready);

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bale_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_data_reg <= {5'd0, result.element_count, result.found_index,
                           result.read_word, result.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    bale_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cap_limit (cap_reg),
        .take      (take),
        .idle      (core_idle),
        .done      (core_done),
        .result    (result)
    );

endmodule
